>>> rtl/bdm_pkg.sv
// Shared types, command constants and frame tables for the background debug
// host sequencer. Used by bdm_seq_core and bdm_host_command_sequencer.
package bdm_pkg;

  localparam int FRAME_BITS = 17;

  localparam logic [15:0] CMD_WRITE_LONG = 16'h1880;
  localparam logic [15:0] CMD_WRITE_WORD = 16'h1840;
  localparam logic [15:0] CMD_READ_WORD  = 16'h1940;
  localparam logic [15:0] CMD_DUMP_WORD  = 16'h1d40;
  localparam logic [15:0] CMD_WRITE_SYS  = 16'h2480;
  localparam logic [15:0] CMD_GO         = 16'h0c00;
  localparam logic [15:0] CMD_NOP        = 16'h0000;

  typedef enum logic [3:0] {
    OP_IDLE        = 4'd0,
    OP_WRITE_LONG  = 4'd1,
    OP_WRITE_WORD  = 4'd2,
    OP_READ_WORD   = 4'd3,
    OP_DUMP_WORD   = 4'd4,
    OP_WRITE_REG   = 4'd5,
    OP_WRITE_SYS   = 4'd6,
    OP_READ_REG    = 4'd7,
    OP_GO          = 4'd8
  } op_t;

  localparam logic [3:0] FUNC_TICK = 4'd0;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] address;
    logic [31:0] data_value;
    logic [15:0] command_word;
    logic [3:0]  sysreg_select;
    logic        dso_level;
  } in_item_t;

  typedef struct packed {
    logic        dsi_level;
    logic        clock_pulse;
    logic        accepted;
    logic        done_res;
    logic [31:0] read_data;
    logic        status_bit;
  } result_t;

  function automatic logic [2:0] frame_last(op_t op);
    logic [2:0] last;
    unique case (op)
      OP_WRITE_LONG: last = 3'd4;
      OP_WRITE_WORD: last = 3'd3;
      OP_READ_WORD:  last = 3'd3;
      OP_DUMP_WORD:  last = 3'd1;
      OP_WRITE_REG:  last = 3'd2;
      OP_WRITE_SYS:  last = 3'd2;
      OP_READ_REG:   last = 3'd2;
      OP_GO:         last = 3'd1;
      default:       last = 3'd0;
    endcase
    return last;
  endfunction

  function automatic logic [15:0] frame_word(op_t op, logic [2:0] idx, logic [31:0] addr,
                                             logic [31:0] data, logic [15:0] cmd);
    logic [15:0] w;
    w = CMD_NOP;
    unique case (op)
      OP_WRITE_LONG: begin
        case (idx)
          3'd0:    w = CMD_WRITE_LONG;
          3'd1:    w = addr[31:16];
          3'd2:    w = addr[15:0];
          3'd3:    w = data[31:16];
          3'd4:    w = data[15:0];
          default: w = CMD_NOP;
        endcase
      end
      OP_WRITE_WORD: begin
        case (idx)
          3'd0:    w = CMD_WRITE_WORD;
          3'd1:    w = addr[31:16];
          3'd2:    w = addr[15:0];
          3'd3:    w = data[15:0];
          default: w = CMD_NOP;
        endcase
      end
      OP_READ_WORD: begin
        case (idx)
          3'd0:    w = CMD_READ_WORD;
          3'd1:    w = addr[31:16];
          3'd2:    w = addr[15:0];
          default: w = CMD_NOP;
        endcase
      end
      OP_DUMP_WORD: w = (idx == 3'd0) ? CMD_DUMP_WORD : CMD_NOP;
      OP_WRITE_REG, OP_WRITE_SYS: begin
        case (idx)
          3'd0:    w = cmd;
          3'd1:    w = data[31:16];
          default: w = data[15:0];
        endcase
      end
      OP_READ_REG:  w = (idx == 3'd0) ? cmd : CMD_NOP;
      OP_GO:        w = (idx == 3'd0) ? CMD_NOP : CMD_GO;
      default:      w = CMD_NOP;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/bdm_seq_core.sv
// Command sequencer state: operation capture, frame and bit counting, serial
// shift registers and read-back accumulation. Depends on bdm_pkg.
module bdm_seq_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_en,
  input  bdm_pkg::in_item_t item,
  output bdm_pkg::result_t  res
);
  import bdm_pkg::*;

  op_t         op_r, op_nxt;
  logic [2:0]  frame_index_r, frame_index_nxt;
  logic [4:0]  bit_index_r, bit_index_nxt;
  logic [16:0] out_shift_r, out_shift_nxt;
  logic [16:0] in_shift_r, in_shift_nxt;
  logic [31:0] held_address_r, held_address_nxt;
  logic [31:0] held_data_r, held_data_nxt;
  logic [15:0] held_command_r, held_command_nxt;
  logic [31:0] read_accum_r, read_accum_nxt;

  op_t         func_op;
  logic        is_operation;
  logic [15:0] cmd_in;
  logic [16:0] shift_in;
  logic [4:0]  bit_inc;
  logic [2:0]  last;
  logic [15:0] word;

  assign func_op      = op_t'(item.func);
  assign is_operation = (item.func >= OP_WRITE_LONG) && (item.func <= OP_GO);
  assign cmd_in       = (func_op == OP_WRITE_SYS) ? (CMD_WRITE_SYS | {12'd0, item.sysreg_select})
                                                  : item.command_word;
  assign shift_in     = {in_shift_r[15:0], item.dso_level};
  assign bit_inc      = bit_index_r + 5'd1;
  assign last         = frame_last(op_r);
  assign word         = shift_in[15:0];

  always_comb begin
    op_nxt           = op_r;
    frame_index_nxt  = frame_index_r;
    bit_index_nxt    = bit_index_r;
    out_shift_nxt    = out_shift_r;
    in_shift_nxt     = in_shift_r;
    held_address_nxt = held_address_r;
    held_data_nxt    = held_data_r;
    held_command_nxt = held_command_r;
    read_accum_nxt   = read_accum_r;
    res              = '0;
    if (item_en) begin
      if (is_operation) begin
        if (op_r == OP_IDLE) begin
          res.accepted     = 1'b1;
          op_nxt           = func_op;
          held_address_nxt = item.address;
          held_data_nxt    = item.data_value;
          held_command_nxt = cmd_in;
          read_accum_nxt   = '0;
          frame_index_nxt  = '0;
          bit_index_nxt    = '0;
          out_shift_nxt    = {1'b0, frame_word(func_op, 3'd0, item.address,
                                               item.data_value, cmd_in)};
        end
      end else if (item.func == FUNC_TICK && op_r != OP_IDLE) begin
        res.clock_pulse = 1'b1;
        res.dsi_level   = out_shift_r[16];
        out_shift_nxt   = {out_shift_r[15:0], 1'b0};
        in_shift_nxt    = shift_in;
        bit_index_nxt   = bit_inc;
        if (bit_inc >= 5'(FRAME_BITS)) begin
          if ((op_r == OP_READ_WORD || op_r == OP_DUMP_WORD) && frame_index_r == last) begin
            read_accum_nxt = {16'd0, word};
          end else if (op_r == OP_READ_REG && frame_index_r == 3'd1) begin
            read_accum_nxt = {word, 16'd0};
          end else if (op_r == OP_READ_REG && frame_index_r == 3'd2) begin
            read_accum_nxt = {read_accum_r[31:16], word};
          end
          bit_index_nxt = '0;
          if (frame_index_r >= last) begin
            res.done_res    = 1'b1;
            res.status_bit  = shift_in[16];
            res.read_data   = read_accum_nxt;
            op_nxt          = OP_IDLE;
            frame_index_nxt = '0;
            out_shift_nxt   = '0;
          end else begin
            frame_index_nxt = frame_index_r + 3'd1;
            out_shift_nxt   = {1'b0, frame_word(op_r, frame_index_r + 3'd1, held_address_r,
                                                 held_data_r, held_command_r)};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r           <= OP_IDLE;
      frame_index_r  <= '0;
      bit_index_r    <= '0;
      out_shift_r    <= '0;
      in_shift_r     <= '0;
      held_address_r <= '0;
      held_data_r    <= '0;
      held_command_r <= '0;
      read_accum_r   <= '0;
    end else begin
      op_r           <= op_nxt;
      frame_index_r  <= frame_index_nxt;
      bit_index_r    <= bit_index_nxt;
      out_shift_r    <= out_shift_nxt;
      in_shift_r     <= in_shift_nxt;
      held_address_r <= held_address_nxt;
      held_data_r    <= held_data_nxt;
      held_command_r <= held_command_nxt;
      read_accum_r   <= read_accum_nxt;
    end
  end

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r == OP_IDLE) |-> (frame_index_r == 3'd0 && bit_index_r == 5'd0))
    else $error("counters not clear while idle");

  a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_index_r < 5'(FRAME_BITS))
    else $error("bit index beyond frame");

  a_frame_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r != OP_IDLE) |-> (frame_index_r <= frame_last(op_r)))
    else $error("frame index beyond last frame");

endmodule

>>> rtl/bdm_host_command_sequencer.sv
// Throughput: one item per cycle while the skid stage is empty. The sequencer
// state updates at acceptance; results are registered in the result register,
// or first in one skid stage under stall; both decouple the output side.
// Reset: synchronous, active low; clears sequencer state and output valids.
// Top level of the background debug host sequencer. Depends on bdm_pkg, bdm_seq_core.
module bdm_host_command_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_func,
  input  logic [31:0] in_address,
  input  logic [31:0] in_data_value,
  input  logic [15:0] in_command_word,
  input  logic [3:0]  in_sysreg_select,
  input  logic        in_dso_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_dsi_level,
  output logic        out_clock_pulse,
  output logic        out_accepted,
  output logic        out_done_res,
  output logic [31:0] out_read_data,
  output logic        out_status_bit
);
  import bdm_pkg::*;

  in_item_t item;
  result_t  res;
  result_t  out_r, out_nxt;
  result_t  skid_r, skid_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  logic     in_take, out_take;

  assign item     = '{func: in_func, address: in_address, data_value: in_data_value,
                      command_word: in_command_word, sysreg_select: in_sysreg_select,
                      dso_level: in_dso_level};
  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  bdm_seq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (in_take),
    .item    (item),
    .res     (res)
  );

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = in_take;
      end else begin
        out_nxt        = res;
        out_valid_nxt  = in_take;
      end
    end else if (in_take) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_dsi_level   = out_r.dsi_level;
  assign out_clock_pulse = out_r.clock_pulse;
  assign out_accepted    = out_r.accepted;
  assign out_done_res    = out_r.done_res;
  assign out_read_data   = out_r.read_data;
  assign out_status_bit  = out_r.status_bit;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_done_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> out_clock_pulse)
    else $error("done without a clocked bit");

  a_accept_not_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (!out_clock_pulse && !out_dsi_level))
    else $error("operation result carries a clocked bit");

  a_fill_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("item taken under stall not held in skid");

endmodule

>>> dv/tb_bdm_host_command_sequencer.sv
// Self-checking bench for bdm_host_command_sequencer: directed and random command
// sequences with bit ticks, checked against a cycle-free frame predictor.
// Depends on bdm_pkg and the sequencer RTL.
module tb_bdm_host_command_sequencer;
  import bdm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_func = FUNC_TICK;
  logic [31:0] in_address = '0;
  logic [31:0] in_data_value = '0;
  logic [15:0] in_command_word = '0;
  logic [3:0]  in_sysreg_select = '0;
  logic        in_dso_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_dsi_level;
  logic        out_clock_pulse;
  logic        out_accepted;
  logic        out_done_res;
  logic [31:0] out_read_data;
  logic        out_status_bit;

  in_item_t pending_items[$];
  result_t  expected_results[$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     recv_hold = 1'b0;
  logic     in_taken = 1'b0;

  // predictor state
  op_t         cur_op = OP_IDLE;
  logic [2:0]  frame_no = '0;
  logic [4:0]  bit_no = '0;
  logic [16:0] tx_shift = '0;
  logic [16:0] rx_shift = '0;
  logic [31:0] held_addr = '0;
  logic [31:0] held_data = '0;
  logic [15:0] held_cmd = '0;
  logic [31:0] rd_accum = '0;

  bdm_host_command_sequencer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_address       (in_address),
    .in_data_value    (in_data_value),
    .in_command_word  (in_command_word),
    .in_sysreg_select (in_sysreg_select),
    .in_dso_level     (in_dso_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dsi_level    (out_dsi_level),
    .out_clock_pulse  (out_clock_pulse),
    .out_accepted     (out_accepted),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_status_bit   (out_status_bit)
  );

  always #10 clk = ~clk;

  function automatic logic [2:0] frames_of(op_t op);
    case (op)
      OP_WRITE_LONG:                                  return 3'd5;
      OP_WRITE_WORD, OP_READ_WORD:                    return 3'd4;
      OP_WRITE_REG, OP_WRITE_SYS, OP_READ_REG:        return 3'd3;
      OP_DUMP_WORD, OP_GO:                            return 3'd2;
      default:                                        return 3'd0;
    endcase
  endfunction

  function automatic logic [15:0] frame_payload(logic [2:0] idx);
    logic [15:0] w;
    w = CMD_NOP;
    case (cur_op)
      OP_WRITE_LONG:
        case (idx)
          3'd0: w = CMD_WRITE_LONG;
          3'd1: w = held_addr[31:16];
          3'd2: w = held_addr[15:0];
          3'd3: w = held_data[31:16];
          3'd4: w = held_data[15:0];
          default: w = CMD_NOP;
        endcase
      OP_WRITE_WORD:
        case (idx)
          3'd0: w = CMD_WRITE_WORD;
          3'd1: w = held_addr[31:16];
          3'd2: w = held_addr[15:0];
          3'd3: w = held_data[15:0];
          default: w = CMD_NOP;
        endcase
      OP_READ_WORD:
        case (idx)
          3'd0: w = CMD_READ_WORD;
          3'd1: w = held_addr[31:16];
          3'd2: w = held_addr[15:0];
          default: w = CMD_NOP;
        endcase
      OP_DUMP_WORD: w = (idx == 3'd0) ? CMD_DUMP_WORD : CMD_NOP;
      OP_WRITE_REG, OP_WRITE_SYS:
        w = (idx == 3'd0) ? held_cmd : (idx == 3'd1) ? held_data[31:16] : held_data[15:0];
      OP_READ_REG: w = (idx == 3'd0) ? held_cmd : CMD_NOP;
      OP_GO: w = (idx == 3'd0) ? CMD_NOP : CMD_GO;
      default: w = CMD_NOP;
    endcase
    return w;
  endfunction

  function automatic result_t predict_bdm_result(in_item_t it);
    result_t    r;
    logic [2:0] last;
    r = '0;
    if (it.func >= 4'd1 && it.func <= 4'd8) begin
      if (cur_op == OP_IDLE) begin
        r.accepted = 1'b1;
        cur_op     = op_t'(it.func);
        held_addr  = it.address;
        held_data  = it.data_value;
        held_cmd   = (cur_op == OP_WRITE_SYS) ? (CMD_WRITE_SYS | {12'h0, it.sysreg_select})
                                              : it.command_word;
        rd_accum   = '0;
        frame_no   = '0;
        bit_no     = '0;
        tx_shift   = {1'b0, frame_payload(3'd0)};
      end
    end else if (it.func == FUNC_TICK && cur_op != OP_IDLE) begin
      r.clock_pulse = 1'b1;
      r.dsi_level   = tx_shift[16];
      tx_shift      = {tx_shift[15:0], 1'b0};
      rx_shift      = {rx_shift[15:0], it.dso_level};
      bit_no        = bit_no + 5'd1;
      if (bit_no >= FRAME_BITS) begin
        last = frames_of(cur_op) - 3'd1;
        if ((cur_op == OP_READ_WORD || cur_op == OP_DUMP_WORD) && frame_no == last)
          rd_accum = {16'h0, rx_shift[15:0]};
        else if (cur_op == OP_READ_REG && frame_no == 3'd1)
          rd_accum = {rx_shift[15:0], 16'h0};
        else if (cur_op == OP_READ_REG && frame_no == 3'd2)
          rd_accum[15:0] = rx_shift[15:0];
        bit_no = '0;
        if (frame_no >= last) begin
          r.done_res   = 1'b1;
          r.status_bit = rx_shift[16];
          r.read_data  = rd_accum;
          cur_op       = OP_IDLE;
          frame_no     = '0;
          tx_shift     = '0;
        end else begin
          frame_no = frame_no + 3'd1;
          tx_shift = {1'b0, frame_payload(frame_no)};
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100)
      $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic push_item(logic [3:0] func, logic [31:0] addr, logic [31:0] data,
                           logic [15:0] cmd, logic [3:0] sel, logic dso);
    in_item_t it;
    it.func          = func;
    it.address       = addr;
    it.data_value    = data;
    it.command_word  = cmd;
    it.sysreg_select = sel;
    it.dso_level     = dso;
    pending_items.push_back(it);
  endtask

  // dso_mode: 0 all low, 1 all high, 2 random
  task automatic push_ticks(int n, int dso_mode);
    for (int i = 0; i < n; i++)
      push_item(FUNC_TICK, $urandom, $urandom, 16'($urandom), 4'($urandom),
                (dso_mode == 2) ? 1'($urandom) : 1'(dso_mode));
  endtask

  task automatic push_random_op(op_t op);
    push_item(op, $urandom, $urandom, 16'($urandom), 4'($urandom), 1'($urandom));
  endtask

  task automatic push_random_traffic(int n_items);
    int   start;
    int   cut;
    op_t  op;
    start = pending_items.size();
    while (pending_items.size() - start < n_items) begin
      if ($urandom_range(99) < 85) begin
        op = op_t'($urandom_range(1, 8));
        push_random_op(op);
        if ($urandom_range(9) == 0) begin
          // busy operation mid-command, then complete the command
          cut = $urandom_range(1, frames_of(op) * FRAME_BITS - 1);
          push_ticks(cut, 2);
          push_random_op(op_t'($urandom_range(1, 8)));
          push_ticks(frames_of(op) * FRAME_BITS - cut, 2);
        end else if ($urandom_range(19) == 0) begin
          // truncated command; following operations hit a busy block
          push_ticks($urandom_range(1, 30), 2);
        end else begin
          push_ticks(frames_of(op) * FRAME_BITS, $urandom_range(3) == 0 ? $urandom_range(1) : 2);
        end
      end else if ($urandom_range(1) == 0) begin
        push_ticks($urandom_range(1, 3), 2);
      end else begin
        push_item(4'($urandom_range(9, 15)), $urandom, $urandom, 16'($urandom),
                  4'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic wait_all_done();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // sender: take a new item only once the current one has gone
  always @(negedge clk) begin : drive_items
    in_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_func          <= it.func;
        in_address       <= it.address;
        in_data_value    <= it.data_value;
        in_command_word  <= it.command_word;
        in_sysreg_select <= it.sysreg_select;
        in_dso_level     <= it.dso_level;
        in_valid         <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : take_items
    in_item_t it;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      it.func          = in_func;
      it.address       = in_address;
      it.data_value    = in_data_value;
      it.command_word  = in_command_word;
      it.sysreg_select = in_sysreg_select;
      it.dso_level     = in_dso_level;
      expected_results.push_back(predict_bdm_result(it));
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("dsi_level", 32'(out_dsi_level), 32'(want.dsi_level));
        check_field("clock_pulse", 32'(out_clock_pulse), 32'(want.clock_pulse));
        check_field("accepted", 32'(out_accepted), 32'(want.accepted));
        check_field("done_res", 32'(out_done_res), 32'(want.done_res));
        check_field("read_data", out_read_data, want.read_data);
        check_field("status_bit", 32'(out_status_bit), 32'(want.status_bit));
      end
    end
  end

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle ticks and out-of-range functions are ignored
    push_item(FUNC_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 1'b1);
    push_item(4'd9, 32'h0, 32'h0, 16'h0, 4'h0, 1'b0);
    push_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 1'b1);
    push_item(OP_WRITE_LONG, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0, 4'h0, 1'b0);
    push_ticks(5 * FRAME_BITS, 1);
    push_item(OP_WRITE_WORD, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 1'b1);
    push_ticks(4 * FRAME_BITS, 0);
    push_item(OP_READ_WORD, 32'h8000_0001, 32'h0, 16'h0, 4'h0, 1'b0);
    push_ticks(4 * FRAME_BITS, 1);
    push_item(OP_DUMP_WORD, 32'h0, 32'h0, 16'h0, 4'h0, 1'b0);
    push_ticks(2 * FRAME_BITS, 0);
    push_item(OP_WRITE_REG, 32'h0, 32'hA5A5_5A5A, 16'hFFFF, 4'h0, 1'b0);
    push_ticks(3 * FRAME_BITS, 2);
    push_item(OP_WRITE_SYS, 32'h0, 32'h1234_5678, 16'hFFFF, 4'hF, 1'b0);
    push_ticks(3 * FRAME_BITS, 2);
    push_item(OP_WRITE_SYS, 32'h0, 32'hFFFF_FFFF, 16'h0, 4'h0, 1'b0);
    push_ticks(3 * FRAME_BITS, 2);
    push_item(OP_READ_REG, 32'h0, 32'h0, 16'h0000, 4'h0, 1'b0);
    push_ticks(3 * FRAME_BITS, 1);
    push_item(OP_READ_REG, 32'h0, 32'h0, 16'hFFFF, 4'h0, 1'b0);
    push_ticks(3 * FRAME_BITS, 2);
    push_item(OP_GO, 32'h0, 32'h0, 16'h0, 4'h0, 1'b0);
    push_ticks(10, 2);
    push_item(OP_READ_WORD, 32'hFFFF_FFFF, 32'h0, 16'h0, 4'h0, 1'b0);
    push_ticks(2 * FRAME_BITS - 10, 2);
    push_item(FUNC_TICK, 32'h0, 32'h0, 16'h0, 4'h0, 1'b1);
    wait_all_done();

    send_idle_pct = 0;  recv_stall_pct = 0;
    push_random_traffic(210);
    wait_all_done();
    send_idle_pct = 67; recv_stall_pct = 0;
    push_random_traffic(210);
    wait_all_done();
    send_idle_pct = 0;  recv_stall_pct = 67;
    push_random_traffic(210);
    wait_all_done();
    send_idle_pct = 16; recv_stall_pct = 16;
    push_random_traffic(210);
    wait_all_done();

    // hold the receiver off while the sender keeps offering items
    send_idle_pct = 0;  recv_stall_pct = 0;
    push_random_traffic(210);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (200) @(posedge clk);
    recv_hold = 1'b0;
    wait_all_done();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
